FILE: hw/rtl/psplit_pkg.sv
// Package for the process argument region splitter.
// Types, section and status codes, and the key text; used by all modules.
// No dependencies.
package psplit_pkg;

   localparam int MAX_REGION_BYTES = 262144;
   localparam int OFS_W = 19;
   localparam int COUNT_W = 32;
   localparam int KEY_LEN = 16;
   localparam int MATCH_W = 5;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [MATCH_W-1:0] KEY_MISS = 5'd31;

   // key string, index 0 first
   localparam logic [KEY_LEN-1:0][7:0] KEY_TEXT = {
      8'h3d, 8'h68, 8'h74, 8'h61, 8'h70, 8'h5f, 8'h65, 8'h6c,
      8'h62, 8'h61, 8'h74, 8'h75, 8'h63, 8'h65, 8'h78, 8'h65
   };

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_PATH  = 3'd1,
      PH_PAD   = 3'd2,
      PH_ARGS  = 3'd3,
      PH_ENV   = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_SHORT    = 2'd2,
      ST_BAD_CNT  = 2'd3
   } status_type;

   // classified input beat
   typedef struct packed {
      logic [7:0]         data_byte;
      logic               has_byte;
      logic               last;
      logic               is_zero;
      logic [KEY_LEN-1:0] key_hit;
   } beat_type;

endpackage

FILE: hw/rtl/psplit_front.sv
// Front end: classifies each input beat (NUL test, key character compares).
// Depends on psplit_pkg.
module psplit_front (
   input  logic [7:0]         data_byte,
   input  logic               has_byte,
   input  logic               last,
   output psplit_pkg::beat_type beat,
   output logic               keep
);

   always_comb begin
      beat.data_byte = data_byte;
      beat.has_byte  = has_byte;
      beat.last      = last;
      beat.is_zero   = (data_byte == 8'd0);
      for (int i = 0; i < psplit_pkg::KEY_LEN; i++) begin
         beat.key_hit[i] = (data_byte == psplit_pkg::KEY_TEXT[i]);
      end
      // a bare beat without end marker does nothing
      keep = has_byte | last;
   end

endmodule

FILE: hw/rtl/psplit_fifo.sv
// Short queue of classified beats between front and back end.
// Depends on psplit_pkg.
module psplit_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  psplit_pkg::beat_type wr_beat,
   output logic                 full,
   input  logic                 rd_en,
   output psplit_pkg::beat_type rd_beat,
   output logic                 empty
);

   psplit_pkg::beat_type mem_ff [psplit_pkg::FIFO_DEPTH];
   logic [psplit_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [psplit_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [psplit_pkg::FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic do_wr, do_rd;

   assign full    = (cnt_ff == psplit_pkg::FIFO_CNT_W'(psplit_pkg::FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_beat = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_beat;
      end
   end

endmodule

FILE: hw/rtl/psplit_back.sv
// Back end: section scanner state machine and the one-entry result register.
// Depends on psplit_pkg.
module psplit_back (
   input  logic                 clock,
   input  logic                 reset,
   input  psplit_pkg::beat_type beat,
   input  logic                 beat_valid,
   output logic                 beat_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_status,
   output logic [psplit_pkg::OFS_W-1:0] rsp_region_length,
   output logic [psplit_pkg::OFS_W-1:0] rsp_argv_start,
   output logic [psplit_pkg::OFS_W-1:0] rsp_env_start,
   output logic [psplit_pkg::OFS_W-1:0] rsp_apple_start
);

   localparam int W = psplit_pkg::OFS_W;
   localparam int CW = psplit_pkg::COUNT_W;
   localparam int MW = psplit_pkg::MATCH_W;

   psplit_pkg::phase_type phase_ff, phase_in;
   logic [W-1:0]  pos_ff, pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  skipped_ff, skipped_in;
   logic [MW-1:0] match_ff, match_in;
   logic [W-1:0]  str_ff, str_in;
   logic [W-1:0]  argv_ff, argv_in;
   logic [W-1:0]  env_ff, env_in;
   logic [W-1:0]  apple_ff, apple_in;
   logic          found_ff, found_in;

   logic          valid_ff, valid_in;
   psplit_pkg::status_type status_ff, status_in;
   logic [W-1:0]  len_ff, len_in, av_ff, av_in, ev_ff, ev_in, ap_ff, ap_in;

   logic          take;
   logic          count_bad;
   logic [W-1:0]  pos_next;

   assign beat_take         = beat_valid & (~beat.last | ~valid_ff | rsp_pop);
   assign rsp_empty         = ~valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_region_length = len_ff;
   assign rsp_argv_start    = av_ff;
   assign rsp_env_start     = ev_ff;
   assign rsp_apple_start   = ap_ff;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      skipped_in = skipped_ff;
      match_in   = match_ff;
      str_in     = str_ff;
      argv_in    = argv_ff;
      env_in     = env_ff;
      apple_in   = apple_ff;
      found_in   = found_ff;
      pos_next   = pos_ff + 1'b1;
      take       = beat_take & beat.has_byte &
                   (pos_ff < W'(psplit_pkg::MAX_REGION_BYTES));

      if (take) begin
         pos_in = pos_next;
         case (phase_ff)
            psplit_pkg::PH_COUNT: begin
               count_in = count_ff | ({24'd0, beat.data_byte} << {pos_ff[1:0], 3'b000});
               if (pos_ff[1:0] == 2'd3) begin
                  if (count_in == '0 || count_in[CW-1]) begin
                     phase_in = psplit_pkg::PH_DONE;
                  end else begin
                     phase_in = psplit_pkg::PH_PATH;
                  end
               end
            end
            psplit_pkg::PH_PATH: begin
               if (beat.is_zero) begin
                  phase_in = psplit_pkg::PH_PAD;
               end
            end
            psplit_pkg::PH_PAD: begin
               if (!beat.is_zero) begin
                  argv_in  = pos_ff;
                  phase_in = psplit_pkg::PH_ARGS;
               end
            end
            psplit_pkg::PH_ARGS: begin
               if (beat.is_zero) begin
                  skipped_in = skipped_ff + 1'b1;
                  if ({{(CW-W){1'b0}}, skipped_in} >= count_ff) begin
                     env_in   = pos_next;
                     str_in   = pos_next;
                     match_in = '0;
                     phase_in = psplit_pkg::PH_ENV;
                  end
               end
            end
            psplit_pkg::PH_ENV: begin
               if (beat.is_zero) begin
                  str_in   = pos_next;
                  match_in = '0;
               end else if (!match_ff[MW-1] && beat.key_hit[match_ff[MW-2:0]]) begin
                  match_in = match_ff + 1'b1;
                  if (match_ff == MW'(psplit_pkg::KEY_LEN - 1)) begin
                     found_in = 1'b1;
                     apple_in = str_ff;
                     phase_in = psplit_pkg::PH_DONE;
                  end
               end else begin
                  match_in = psplit_pkg::KEY_MISS;
               end
            end
            default: begin
            end
         endcase
      end

      // result from the state after this beat's byte
      count_bad = (count_in == '0) | count_in[CW-1];
      status_in = psplit_pkg::ST_OK;
      len_in    = pos_in;
      av_in     = '0;
      ev_in     = '0;
      ap_in     = '0;
      if (pos_in == '0) begin
         status_in = psplit_pkg::ST_EMPTY;
      end else if (pos_in < W'(4)) begin
         status_in = psplit_pkg::ST_SHORT;
      end else if (count_bad) begin
         status_in = psplit_pkg::ST_BAD_CNT;
      end else if (phase_in == psplit_pkg::PH_PATH || phase_in == psplit_pkg::PH_PAD) begin
         av_in = pos_in;
         ev_in = pos_in;
         ap_in = pos_in;
      end else if (phase_in == psplit_pkg::PH_ARGS) begin
         av_in = argv_in;
         ev_in = pos_in;
         ap_in = pos_in;
      end else begin
         av_in = argv_in;
         ev_in = env_in;
         ap_in = found_in ? apple_in : pos_in;
      end

      valid_in = valid_ff & ~rsp_pop;
      if (beat_take && beat.last) begin
         valid_in   = 1'b1;
         phase_in   = psplit_pkg::PH_COUNT;
         pos_in     = '0;
         count_in   = '0;
         skipped_in = '0;
         match_in   = '0;
         str_in     = '0;
         argv_in    = '0;
         env_in     = '0;
         apple_in   = '0;
         found_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= psplit_pkg::PH_COUNT;
         pos_ff     <= '0;
         count_ff   <= '0;
         skipped_ff <= '0;
         match_ff   <= '0;
         str_ff     <= '0;
         argv_ff    <= '0;
         env_ff     <= '0;
         apple_ff   <= '0;
         found_ff   <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         count_ff   <= count_in;
         skipped_ff <= skipped_in;
         match_ff   <= match_in;
         str_ff     <= str_in;
         argv_ff    <= argv_in;
         env_ff     <= env_in;
         apple_ff   <= apple_in;
         found_ff   <= found_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_take && beat.last) begin
         status_ff <= status_in;
         len_ff    <= len_in;
         av_ff     <= av_in;
         ev_ff     <= ev_in;
         ap_ff     <= ap_in;
      end
   end

endmodule

FILE: hw/rtl/process_args_region_splitter_unit.sv
// Process argument region splitter, top level.
// A beat with the end marker is written into the beat queue, then taken by the scanner,
// and its result is registered in the result register when the scanner takes it.
// Throughput: one beat per cycle while the queue has room; the scanner takes one
// queued beat each cycle but for a stall: a waiting result stalls the scanner only
// on the next end-marker beat; the 4-entry beat queue keeps the input open meanwhile.
// Reset (synchronous): queue emptied, scanner at the count phase, no result.
module process_args_region_splitter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [psplit_pkg::OFS_W-1:0] rsp_region_length,
   output logic [psplit_pkg::OFS_W-1:0] rsp_argv_start,
   output logic [psplit_pkg::OFS_W-1:0] rsp_env_start,
   output logic [psplit_pkg::OFS_W-1:0] rsp_apple_start
);

   psplit_pkg::beat_type in_beat, q_beat;
   logic keep, q_empty, q_take;

   psplit_front u_front (
      .data_byte (req_data_byte),
      .has_byte  (req_has_byte),
      .last      (req_last),
      .beat      (in_beat),
      .keep      (keep)
   );

   psplit_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push & keep),
      .wr_beat (in_beat),
      .full    (req_full),
      .rd_en   (q_take),
      .rd_beat (q_beat),
      .empty   (q_empty)
   );

   psplit_back u_back (
      .clock             (clock),
      .reset             (reset),
      .beat              (q_beat),
      .beat_valid        (~q_empty),
      .beat_take         (q_take),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_region_length (rsp_region_length),
      .rsp_argv_start    (rsp_argv_start),
      .rsp_env_start     (rsp_env_start),
      .rsp_apple_start   (rsp_apple_start)
   );

endmodule

FILE: hw/rtl/psplit_checker.sv
// Port-level checks for the region splitter, bound to the top level.
// Depends on psplit_pkg and process_args_region_splitter_unit.
module psplit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_status,
   input  logic [psplit_pkg::OFS_W-1:0] rsp_region_length,
   input  logic [psplit_pkg::OFS_W-1:0] rsp_argv_start,
   input  logic [psplit_pkg::OFS_W-1:0] rsp_env_start,
   input  logic [psplit_pkg::OFS_W-1:0] rsp_apple_start
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_status) &&
      $stable(rsp_region_length) && $stable(rsp_argv_start) &&
      $stable(rsp_env_start) && $stable(rsp_apple_start)))
      else $error("waiting result changed");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != psplit_pkg::ST_OK) |->
      (rsp_argv_start == '0 && rsp_env_start == '0 && rsp_apple_start == '0))
      else $error("offsets set on failed region");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == psplit_pkg::ST_OK) |->
      (rsp_argv_start <= rsp_env_start && rsp_env_start <= rsp_apple_start &&
      rsp_apple_start <= rsp_region_length && rsp_region_length >= 19'd4))
      else $error("section offsets out of order");

   a_short_len: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status == psplit_pkg::ST_EMPTY ||
      rsp_status == psplit_pkg::ST_SHORT)) |-> (rsp_region_length < 19'd4))
      else $error("length disagrees with status");

endmodule

bind process_args_region_splitter_unit psplit_checker u_psplit_checker (.*);
